FILE: hw/rtl/subnet_rule_link_classifier_core_defines.svh
// ----------------------------------------------------------------------------
// Subnet rule link classifier assertion macros
// Shared concurrent assertion forms for the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef SUBNET_RULE_LINK_CLASSIFIER_CORE_DEFINES_SVH
`define SUBNET_RULE_LINK_CLASSIFIER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRLC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srlc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srlc: next-cycle check failed");

`endif

FILE: hw/rtl/srlc_pkg.sv
// ----------------------------------------------------------------------------
// srlc_pkg
// Types, codes and helper functions of the subnet rule link classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package srlc_pkg;

   typedef enum logic [1:0] {
      ACT_WRITE_RULE = 2'd0,
      ACT_COLOR_QUERY = 2'd1,
      ACT_LEVEL_QUERY = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   localparam logic [1:0] KIND_PLAIN = 2'd1;
   localparam logic [1:0] KIND_NESTED = 2'd2;

   localparam logic [1:0] COLOR_NONE = 2'd0;
   localparam logic [1:0] COLOR_PLAIN = 2'd1;
   localparam logic [1:0] COLOR_NESTED = 2'd2;

   localparam logic [5:0] LEVEL_FULL = 6'd32;

   typedef struct packed {
      logic [1:0] action;
      logic [6:0] rule_index;
      logic [1:0] rule_kind;
      logic [31:0] rule_prefix;
      logic [4:0] outer_prefix_len;
      logic [4:0] inner_prefix_len;
      logic [31:0] addr_a;
      logic [31:0] addr_b;
      logic [1:0] color_in;
   } req_type;

   typedef struct packed {
      logic [1:0] color;
      logic [5:0] level;
   } rsp_type;

   // One stored rule, 44 bits wide.
   typedef struct packed {
      logic [1:0] kind;
      logic [31:0] prefix;
      logic [4:0] outer_len;
      logic [4:0] inner_len;
   } rule_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Control from the sequencer to the rule evaluator.
   typedef struct packed {
      logic clear;
      logic update;
   } eval_ctl_type;

   // Network mask for a prefix length; length zero leaves no network bits.
   function automatic logic [31:0] net_mask(input logic [4:0] len);
      net_mask = ~(32'hFFFF_FFFF >> len);
   endfunction

   // Host-bit level for a prefix length.
   function automatic logic [5:0] host_level(input logic [4:0] len);
      host_level = LEVEL_FULL - {1'b0, len};
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/srlc_rule_mem.sv
// ----------------------------------------------------------------------------
// srlc_rule_mem
// Rule table: single write port, single read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module srlc_rule_mem
   import srlc_pkg::*;
#(
   parameter int DEPTH = 128,
   parameter int ADDR_W = 7
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [ADDR_W-1:0] wr_addr,
   input wire rule_type wr_data,
   input wire logic rd_en,
   input wire logic [ADDR_W-1:0] rd_addr,
   output rule_type rd_data
);

   rule_type mem [DEPTH];
   rule_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/srlc_rule_eval.sv
// ----------------------------------------------------------------------------
// srlc_rule_eval
// Matches one rule per cycle against the held query and accumulates the answer.
// ----------------------------------------------------------------------------
`default_nettype none

module srlc_rule_eval
   import srlc_pkg::*;
(
   input wire logic clock,
   input wire eval_ctl_type ctl,
   input wire req_type query,
   input wire rule_type rule,
   output rsp_type result
);

   logic [31:0] addr_a_ff;
   logic [31:0] addr_b_ff;
   logic [1:0] color_in_ff;
   logic is_color_ff;
   logic [1:0] best_ff;
   logic [1:0] best_in;
   logic [5:0] level_ff;
   logic [5:0] level_in;

   logic [31:0] outer_mask;
   logic [31:0] inner_mask;
   logic match_a;
   logic match_b;
   logic same_inner;
   logic [5:0] cand_level;
   logic kind_hit;

   always_comb begin
      outer_mask = net_mask(rule.outer_len);
      inner_mask = net_mask(rule.inner_len);
      match_a = (addr_a_ff & outer_mask) == rule.prefix;
      match_b = (addr_b_ff & outer_mask) == rule.prefix;
      same_inner = (addr_a_ff & inner_mask) == (addr_b_ff & inner_mask);
      cand_level = (color_in_ff == KIND_PLAIN) ? host_level(rule.outer_len)
                                               : host_level(rule.inner_len);
      kind_hit = (rule.kind == color_in_ff) &&
                 ((color_in_ff == KIND_PLAIN) || (color_in_ff == KIND_NESTED));

      best_in = best_ff;
      level_in = level_ff;
      if (ctl.clear) begin
         best_in = COLOR_NONE;
         level_in = (query.color_in == COLOR_NONE) ? LEVEL_FULL : 6'd0;
      end else if (ctl.update) begin
         // A nested hit is final, so it is never downgraded by a plain one.
         if (match_a && match_b && (best_ff != COLOR_NESTED)) begin
            if ((rule.kind == KIND_NESTED) && same_inner) begin
               best_in = COLOR_NESTED;
            end else if (rule.kind == KIND_PLAIN) begin
               best_in = COLOR_PLAIN;
            end
         end
         if (kind_hit && match_a && (cand_level > level_ff)) begin
            level_in = cand_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         addr_a_ff <= query.addr_a;
         addr_b_ff <= query.addr_b;
         color_in_ff <= query.color_in;
         is_color_ff <= (query.action == ACT_COLOR_QUERY);
      end
      best_ff <= best_in;
      level_ff <= level_in;
   end

   always_comb begin
      if (is_color_ff) begin
         result.color = best_ff;
         result.level = 6'd0;
      end else begin
         result.color = COLOR_NONE;
         result.level = level_ff;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/subnet_rule_link_classifier_core.sv
// ----------------------------------------------------------------------------
// subnet_rule_link_classifier_core
// IPv4 subnet rule table with link color and link level queries.
// ----------------------------------------------------------------------------
// The block takes one item at a time: an item is accepted when start is high
// while busy is low. A rule write or an action of three gives no result.
// A color or level query walks the first N table entries,
// where N is rules_in_use capped at TABLE_DEPTH, one entry per cycle through
// the single read port of the rule memory. Its result appears on rsp_item with
// rsp_valid high for exactly one cycle, in the done state that follows the
// walk and the drain state, or in the cycle right after acceptance when N
// is zero. A query keeps busy high through the walk, drain and done states
// (only the done state when N is zero), and the next item can follow once
// busy is low again. The receiver cannot stall: a result must be taken in
// the cycle it is shown. The read port of the rule memory sets the query
// time. The rules_in_use register is written through the csr channel and
// may only change while busy is low; its value is sampled when a query starts.
// Table entries are undefined until written, so software must write every
// entry below rules_in_use before querying. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "subnet_rule_link_classifier_core_defines.svh"

module subnet_rule_link_classifier_core
   import srlc_pkg::*;
#(
   parameter int TABLE_DEPTH = 128
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire req_type req_item,
   output logic rsp_valid,
   output rsp_type rsp_item,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [7:0] csr_wdata
);

   // Address width of the table and width of a counter that can hold its depth.
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   state_type state_ff;
   state_type state_in;
   logic [7:0] rules_ff;
   logic [7:0] rules_in;
   logic [CNT_W-1:0] ptr_ff;
   logic [CNT_W-1:0] ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic rd_valid_ff;
   logic rd_valid_in;

   logic accept;
   logic is_query;
   logic last_read;
   logic [CNT_W-1:0] active_count;
   logic [CNT_W-1:0] ptr_next;
   logic wr_en;
   logic rd_en;
   rule_type wr_rule;
   rule_type rd_rule;
   eval_ctl_type eval_ctl;

   assign accept = start && !busy;
   assign is_query = (req_item.action == ACT_COLOR_QUERY) ||
                     (req_item.action == ACT_LEVEL_QUERY);

   // Entries consulted: the register value, capped at the table depth.
   assign active_count = ({24'd0, rules_ff} > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                               : CNT_W'(rules_ff);
   assign ptr_next = ptr_ff + CNT_W'(1);
   assign last_read = (ptr_next == count_ff);

   // Writes go straight into the table; an index beyond the depth is dropped.
   assign wr_en = accept && (req_item.action == ACT_WRITE_RULE) &&
                  ({25'd0, req_item.rule_index} < 32'(TABLE_DEPTH));
   assign wr_rule = '{kind: req_item.rule_kind,
                      prefix: req_item.rule_prefix,
                      outer_len: req_item.outer_prefix_len,
                      inner_len: req_item.inner_prefix_len};

   srlc_rule_mem #(
      .DEPTH(TABLE_DEPTH),
      .ADDR_W(IDX_W)
   ) u_rule_mem (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(IDX_W'(req_item.rule_index)),
      .wr_data(wr_rule),
      .rd_en(rd_en),
      .rd_addr(ptr_ff[IDX_W-1:0]),
      .rd_data(rd_rule)
   );

   srlc_rule_eval u_rule_eval (
      .clock(clock),
      .ctl(eval_ctl),
      .query(req_item),
      .rule(rd_rule),
      .result(rsp_item)
   );

   // Next-state logic of the query sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_query) begin
               state_in = (active_count == '0) ? ST_DONE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (last_read) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath control of the sequencer.
   always_comb begin
      busy = 1'b1;
      rsp_valid = 1'b0;
      rd_en = 1'b0;
      eval_ctl = '{clear: 1'b0, update: rd_valid_ff};
      ptr_in = ptr_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (accept && is_query) begin
               eval_ctl.clear = 1'b1;
               ptr_in = '0;
               count_in = active_count;
            end
         end
         ST_WALK: begin
            rd_en = 1'b1;
            ptr_in = ptr_next;
         end
         ST_DRAIN: begin
            rd_en = 1'b0;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign rd_valid_in = rd_en;
   assign csr_ready = !busy;
   assign rules_in = (csr_valid && csr_ready) ? csr_wdata : rules_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rules_ff <= 8'd0;
         ptr_ff <= '0;
         count_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rules_ff <= rules_in;
         ptr_ff <= ptr_in;
         count_ff <= count_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // The walk never addresses an entry past the sampled count.
   `SRLC_ASSERT_SAME(a_walk_in_range, clock, reset, state_ff == ST_WALK, ptr_ff < count_ff)
   // Read data is only consumed right after a read was issued in the walk.
   `SRLC_ASSERT_SAME(a_update_after_walk, clock, reset, rd_valid_ff,
                     (state_ff == ST_WALK) || (state_ff == ST_DRAIN))
   // A result is shown for a single cycle and the block is then free again.
   `SRLC_ASSERT_NEXT(a_rsp_one_cycle, clock, reset, rsp_valid, !rsp_valid && !busy)
   // A query with entries to read always passes through the walk.
   `SRLC_ASSERT_SAME(a_drain_from_walk, clock, reset, state_ff == ST_DRAIN,
                     $past(state_ff) == ST_WALK)

endmodule

`default_nettype wire

FILE: tb/sv/tb_subnet_rule_link_classifier_pkg.sv
// ----------------------------------------------------------------------------
// Subnet rule link classifier answer board
// Holds a private copy of the rule table, works out the answer to each
// accepted query and checks the answers that the block returns.
// ----------------------------------------------------------------------------
package tb_subnet_rule_link_classifier_pkg;

   import srlc_pkg::*;

   localparam int unsigned RULE_SLOTS = 128;
   localparam int unsigned REPORT_LIMIT = 10;

   class link_answer_board;

      rule_type rules[RULE_SLOTS];
      int unsigned active_rules;
      rsp_type pending_answers[$];
      int unsigned mismatches;

      function new();
         foreach (rules[i]) begin
            rules[i] = '0;
         end
         active_rules = 0;
         mismatches = 0;
      endfunction

      // Mask of the host bits below a prefix length; length zero means all 32.
      static function logic [31:0] host_bits(input logic [4:0] len);
         if (len == 5'd0) begin
            return 32'hFFFF_FFFF;
         end
         return (32'd1 << (6'd32 - {1'b0, len})) - 32'd1;
      endfunction

      // The stored prefix is compared as it is, without masking.
      function bit covers(input int unsigned e, input logic [31:0] addr);
         return (addr & ~host_bits(rules[e].outer_len)) == rules[e].prefix;
      endfunction

      function void set_active(input logic [7:0] value);
         active_rules = (value > RULE_SLOTS) ? RULE_SLOTS : int'(value);
      endfunction

      function rsp_type pair_color(input logic [31:0] a, input logic [31:0] b);
         rsp_type answer;
         logic [31:0] inner_net;
         answer = '0;
         answer.color = COLOR_NONE;
         for (int unsigned e = 0; e < active_rules; e++) begin
            if (rules[e].kind != KIND_PLAIN && rules[e].kind != KIND_NESTED) continue;
            if (!covers(e, a) || !covers(e, b)) continue;
            if (rules[e].kind == KIND_PLAIN) begin
               answer.color = COLOR_PLAIN;
            end else begin
               inner_net = ~host_bits(rules[e].inner_len);
               if ((a & inner_net) == (b & inner_net)) begin
                  answer.color = COLOR_NESTED;
                  break;
               end
            end
         end
         return answer;
      endfunction

      function rsp_type addr_level(input logic [31:0] a, input logic [1:0] color_in);
         rsp_type answer;
         logic [5:0] cand;
         answer = '0;
         if (color_in == COLOR_NONE) begin
            answer.level = LEVEL_FULL;
         end else if (color_in == COLOR_PLAIN || color_in == COLOR_NESTED) begin
            for (int unsigned e = 0; e < active_rules; e++) begin
               if (rules[e].kind != color_in || !covers(e, a)) continue;
               cand = LEVEL_FULL - {1'b0, (color_in == COLOR_PLAIN) ? rules[e].outer_len
                                                                   : rules[e].inner_len};
               if (cand > answer.level) answer.level = cand;
            end
         end
         return answer;
      endfunction

      function void note_item(input req_type item);
         case (item.action)
            ACT_WRITE_RULE: begin
               rules[item.rule_index].kind = item.rule_kind;
               rules[item.rule_index].prefix = item.rule_prefix;
               rules[item.rule_index].outer_len = item.outer_prefix_len;
               rules[item.rule_index].inner_len = item.inner_prefix_len;
            end
            ACT_COLOR_QUERY: pending_answers.push_back(pair_color(item.addr_a, item.addr_b));
            ACT_LEVEL_QUERY: pending_answers.push_back(addr_level(item.addr_a, item.color_in));
            default: ;
         endcase
      endfunction

      function void check_answer(input rsp_type got);
         rsp_type want;
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("unexpected answer: color %0d level %0d", got.color, got.level);
            end
            return;
         end
         want = pending_answers.pop_front();
         if (got.color !== want.color || got.level !== want.level) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("answer mismatch: color expected %0d got %0d, level expected %0d got %0d",
                        want.color, got.color, want.level, got.level);
            end
         end
      endfunction

      function int unsigned outstanding();
         return pending_answers.size();
      endfunction

   endclass

endpackage

FILE: tb/sv/tb_subnet_rule_link_classifier_core.sv
// ----------------------------------------------------------------------------
// Subnet rule link classifier testbench
// Loads rule tables, sweeps the rules_in_use register over small, full and
// saturating values, and checks every color and level answer against a
// private copy of the table kept by the answer board.
// ----------------------------------------------------------------------------
module tb_subnet_rule_link_classifier_core;

   import srlc_pkg::*;
   import tb_subnet_rule_link_classifier_pkg::*;

   // Kinds that are stored but never match any address.
   localparam logic [1:0] KIND_VOID_LO = 2'd0;
   localparam logic [1:0] KIND_VOID_HI = 2'd3;

   // The limit leaves ample headroom over the slowest correct run.
   localparam int unsigned LIMIT_CYCLES = 1_500_000;
   localparam int unsigned PHASES = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_item = '0;
   logic rsp_valid;
   rsp_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_wdata = 8'd0;

   link_answer_board board;
   int unsigned cycle_count = 0;
   int unsigned cur_n = 0;
   bit written[RULE_SLOTS];
   logic [31:0] hubs[4];

   // The register sweep: zero, one, the full table and two saturating
   // values, mixed with small tables so that most queries stay short.
   int unsigned phase_sizes[PHASES] = '{3, 0, 16, 128, 1, 255, 24, 200, 10, 7};

   subnet_rule_link_classifier_core u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog: a hung handshake or a lost answer ends the run here.
   initial begin
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // Both channels are sampled with their values from before the edge. The
   // answer is checked before the new item is noted, so an item accepted in
   // the same cycle as an answer never disturbs that answer.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_answer(rsp_item);
         if (start && !busy) board.note_item(req_item);
      end
   end

   // Addresses near a few hubs make rules overlap, so several entries can
   // match one query and the first-nested-match rule gets exercised.
   function automatic logic [31:0] hub_addr();
      if ($urandom_range(0, 1) != 0) begin
         return hubs[$urandom_range(0, 3)] ^ ($urandom & 32'h0000_FFFF);
      end
      return $urandom;
   endfunction

   // An address built from an entry's stored prefix and random host bits.
   // It matches only when the stored prefix has its host bits clear.
   function automatic logic [31:0] member_addr(input int unsigned e);
      return board.rules[e].prefix |
             ($urandom & link_answer_board::host_bits(board.rules[e].outer_len));
   endfunction

   // Every field starts random; fields that an action does not use stay so.
   function automatic req_type random_fields();
      req_type r;
      r.action = 2'($urandom);
      r.rule_index = 7'($urandom);
      r.rule_kind = 2'($urandom);
      r.rule_prefix = $urandom;
      r.outer_prefix_len = 5'($urandom);
      r.inner_prefix_len = 5'($urandom);
      r.addr_a = $urandom;
      r.addr_b = $urandom;
      r.color_in = 2'($urandom);
      return r;
   endfunction

   function automatic req_type rule_item(input logic [6:0] idx, input logic [1:0] kind,
                                         input logic [31:0] prefix, input logic [4:0] olen,
                                         input logic [4:0] ilen);
      req_type r;
      r = random_fields();
      r.action = ACT_WRITE_RULE;
      r.rule_index = idx;
      r.rule_kind = kind;
      r.rule_prefix = prefix;
      r.outer_prefix_len = olen;
      r.inner_prefix_len = ilen;
      return r;
   endfunction

   function automatic req_type query_item(input action_type act, input logic [31:0] a,
                                          input logic [31:0] b, input logic [1:0] cin);
      req_type r;
      r = random_fields();
      r.action = act;
      r.addr_a = a;
      r.addr_b = b;
      r.color_in = cin;
      return r;
   endfunction

   // Mostly well-formed traffic: aligned rules near the hubs and queries
   // whose addresses fall inside a live entry, often in the same inner
   // subnet. The rest is noise, including the ignored action.
   function automatic req_type next_item();
      req_type r;
      int unsigned pick;
      int unsigned e;
      logic [31:0] inner_host;
      r = random_fields();
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         r.action = ACT_WRITE_RULE;
         if (cur_n > 0 && $urandom_range(0, 3) != 0) begin
            r.rule_index = 7'($urandom_range(0, cur_n - 1));
         end
         pick = $urandom_range(0, 19);
         if (pick < 9) r.rule_kind = KIND_PLAIN;
         else if (pick < 18) r.rule_kind = KIND_NESTED;
         else if (pick == 18) r.rule_kind = KIND_VOID_LO;
         else r.rule_kind = KIND_VOID_HI;
         if ($urandom_range(0, 3) != 0) r.outer_prefix_len = 5'($urandom_range(8, 28));
         if ($urandom_range(0, 4) != 0) begin
            r.inner_prefix_len = 5'($urandom_range(r.outer_prefix_len, 31));
         end
         r.rule_prefix = hub_addr();
         if ($urandom_range(0, 9) != 0) begin
            r.rule_prefix &= ~link_answer_board::host_bits(r.outer_prefix_len);
         end
      end else if (pick < 94) begin
         r.action = (pick < 62) ? ACT_COLOR_QUERY : ACT_LEVEL_QUERY;
         if (cur_n > 0 && $urandom_range(0, 4) != 0) begin
            e = $urandom_range(0, cur_n - 1);
            r.addr_a = member_addr(e);
            inner_host = link_answer_board::host_bits(board.rules[e].inner_len);
            case ($urandom_range(0, 3))
               0: r.addr_b = (r.addr_a & ~inner_host) | ($urandom & inner_host);
               1: r.addr_b = member_addr(e);
               2: r.addr_b = r.addr_a;
               default: r.addr_b = hub_addr();
            endcase
         end else begin
            r.addr_a = hub_addr();
            r.addr_b = hub_addr();
         end
         pick = $urandom_range(0, 9);
         if (pick < 4) r.color_in = COLOR_PLAIN;
         else if (pick < 8) r.color_in = COLOR_NESTED;
      end
      return r;
   endfunction

   // Presents one item and returns at the edge that accepts it. Start is
   // left high, so the next call or an idle stretch decides its next value.
   task automatic send(input req_type r);
      if (r.action == ACT_WRITE_RULE) written[r.rule_index] = 1'b1;
      req_item <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic rest(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Holds the sender off until every answer in flight has come back.
   task automatic wait_answers();
      start <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   // A rule write gives no answer, so after the last answer the block may
   // still be finishing a write; wait out one walk of the current table.
   task automatic settle();
      wait_answers();
      repeat (cur_n + 8) @(posedge clock);
   endtask

   task automatic write_rules_in_use(input logic [7:0] value);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.set_active(value);
      cur_n = board.active_rules;
   endtask

   // Entries below rules_in_use must hold a rule before any query reads them.
   task automatic fill_table(input int unsigned upto);
      logic [4:0] olen;
      for (int unsigned i = 0; i < upto; i++) begin
         if (!written[i]) begin
            olen = 5'($urandom_range(8, 28));
            send(rule_item(7'(i), ($urandom_range(0, 1) != 0) ? KIND_PLAIN : KIND_NESTED,
                           hub_addr() & ~link_answer_board::host_bits(olen), olen,
                           5'($urandom_range(olen, 31))));
         end
      end
   endtask

   initial begin
      int unsigned target;
      int unsigned quota;
      int unsigned done;
      int unsigned idle_pct;
      bit held;
      req_type r;

      board = new();
      foreach (hubs[i]) hubs[i] = $urandom;
      foreach (written[i]) written[i] = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With an empty table every color is unrelated, color 0 still gives the
      // full level, and the ignored action must give nothing back.
      send(query_item(ACT_COLOR_QUERY, 32'h0000_0000, 32'hFFFF_FFFF, COLOR_NONE));
      send(query_item(ACT_LEVEL_QUERY, 32'h0A01_0203, 32'h0, COLOR_NONE));
      send(query_item(ACT_LEVEL_QUERY, 32'h0A01_0203, 32'h0, COLOR_PLAIN));
      send(query_item(ACT_LEVEL_QUERY, 32'h0A01_0203, 32'h0, KIND_VOID_HI));
      send(query_item(ACT_NONE, 32'h0A01_0203, 32'h0A01_0203, COLOR_PLAIN));

      // A plain /8, a nested /16 split in /24s, two void kinds that would
      // otherwise match everything, a prefix with host bits set that can
      // never match, a nested catch-all with a /31 inner net, a plain /31
      // and a nested /24 whose inner length of zero joins every pair.
      send(rule_item(7'd0, KIND_PLAIN, 32'h0A00_0000, 5'd8, 5'd0));
      send(rule_item(7'd1, KIND_NESTED, 32'h0A01_0000, 5'd16, 5'd24));
      send(rule_item(7'd2, KIND_VOID_LO, 32'h0000_0000, 5'd0, 5'd0));
      send(rule_item(7'd3, KIND_VOID_HI, 32'h0000_0000, 5'd0, 5'd0));
      send(rule_item(7'd4, KIND_PLAIN, 32'hC0A8_0001, 5'd24, 5'd24));
      send(rule_item(7'd5, KIND_NESTED, 32'h0000_0000, 5'd0, 5'd31));
      send(rule_item(7'd6, KIND_PLAIN, 32'hFFFF_FFFE, 5'd31, 5'd31));
      send(rule_item(7'd7, KIND_NESTED, 32'hFFFF_FF00, 5'd24, 5'd0));
      settle();
      write_rules_in_use(8'd8);

      send(query_item(ACT_COLOR_QUERY, 32'h0A01_0203, 32'h0A01_02FF, COLOR_NONE));
      send(query_item(ACT_COLOR_QUERY, 32'h0A01_0203, 32'h0A01_0303, COLOR_NONE));
      send(query_item(ACT_COLOR_QUERY, 32'h0A00_0001, 32'h0B00_0001, COLOR_NONE));
      send(query_item(ACT_COLOR_QUERY, 32'hFFFF_FFFE, 32'hFFFF_FFFF, COLOR_NONE));
      send(query_item(ACT_COLOR_QUERY, 32'hFFFF_FF01, 32'hFFFF_FF80, COLOR_NONE));
      send(query_item(ACT_LEVEL_QUERY, 32'h0A01_0203, 32'h0, COLOR_PLAIN));
      send(query_item(ACT_LEVEL_QUERY, 32'h0A01_0203, 32'h0, COLOR_NESTED));
      send(query_item(ACT_LEVEL_QUERY, 32'hFFFF_FFFF, 32'h0, COLOR_PLAIN));
      send(query_item(ACT_LEVEL_QUERY, 32'hFFFF_FFFF, 32'h0, COLOR_NESTED));
      send(query_item(ACT_LEVEL_QUERY, 32'hC0A8_0001, 32'h0, KIND_VOID_HI));

      // Random phases. Idling cycles through none, heavy and light gaps on
      // the sender; the receiver side has no stall to apply. Tables of 100
      // entries or more get short phases since every query walks them all.
      for (int unsigned p = 0; p < PHASES; p++) begin
         target = phase_sizes[p];
         fill_table((target > RULE_SLOTS) ? RULE_SLOTS : target);
         settle();
         write_rules_in_use(8'(target));
         case (p % 4)
            1: idle_pct = 57;
            3: idle_pct = 17;
            default: idle_pct = 0;
         endcase
         quota = (cur_n >= 100) ? 60 : 240;
         done = 0;
         held = 1'b0;
         while (done < quota) begin
            r = next_item();
            send(r);
            if (r.action != ACT_NONE) done++;
            if (!held && done == quota / 2) begin
               wait_answers();
               held = 1'b1;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
               rest($urandom_range(1, 6));
            end
         end
      end

      settle();
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
